FILE: sv/i2cms_pkg.sv
// Shared types and codes for the I2C master transfer sequencer.
// Used by i2cms_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps

package i2cms_pkg;

	// Item kinds on the input channel.
	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_START  = 2'd1,
		MODE_STATUS = 2'd2
	} mode_t;

	// Transfer outcome as reported with every result.
	typedef enum logic [2:0] {
		OUT_IDLE      = 3'd0,
		OUT_OK        = 3'd1,
		OUT_NO_DATA   = 3'd2,
		OUT_NACK_DATA = 3'd3,
		OUT_NACK_ADDR = 3'd4,
		OUT_ARB_LOST  = 3'd5
	} outcome_t;

	// Acknowledge control for the next received byte.
	typedef enum logic [1:0] {
		ACK_NONE = 2'd0,
		ACK_ACK  = 2'd1,
		ACK_NACK = 2'd2
	} ack_t;

	// Controller status codes in master mode.
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RESTART     = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
	localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
	localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_LENGTH  = 2'd1;

	// Configuration register contents.
	typedef struct packed {
		logic [3:0] write_length;
		logic [3:0] read_length;
	} cfg_t;

	// Decoded result of one item, without the transmit byte itself.
	typedef struct packed {
		logic       send_valid;
		logic       slot_ok;
		logic       set_start;
		logic       clear_start;
		logic       set_stop;
		ack_t       ack_drive;
		logic       rx_valid;
		logic [3:0] rx_index;
		logic [7:0] rx_data;
		outcome_t   outcome;
	} result_t;

endpackage

FILE: sv/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: config registers, transmit
// buffer RAM, decoder and output register. Depends on i2cms_pkg, i2cms_ram, i2cms_ctrl.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   mode load_index load_byte status_code rx_byte
//   output   out        out_valid / out_stall send_* set_* clear_start ack_drive rx_* outcome
//   config   in         cfg_valid / cfg_ready cfg_index cfg_data
//
// One item is accepted per cycle while in_stall is low; its result appears in the
// next cycle, from the output register and the registered read port of the transmit buffer RAM.
// Reset clears the indexes and the outcome and sets the config registers to their
// defaults; the buffer itself is not cleared and needs no clearing pass.
// While a result waits under out_stall, in_stall is raised; otherwise a new
// request is taken in the same cycle that the old result leaves.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer #(
	parameter int BUF_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      mode,
	input  logic [3:0]                      load_index,
	input  logic [7:0]                      load_byte,
	input  logic [7:0]                      status_code,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            send_valid,
	output logic [7:0]                      send_byte,
	output logic                            set_start,
	output logic                            clear_start,
	output logic                            set_stop,
	output logic [1:0]                      ack_drive,
	output logic                            rx_valid,
	output logic [3:0]                      rx_index,
	output logic [7:0]                      rx_data,
	output logic [2:0]                      outcome,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [i2cms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [3:0]                      cfg_data
);

	localparam int AW = $clog2(BUF_DEPTH);

	i2cms_pkg::cfg_t    cfg_q;
	i2cms_pkg::result_t res_d;
	i2cms_pkg::result_t res_s1;
	logic               valid_s1;
	logic               accept;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [7:0]         ram_rdata;

	// Input handshake: hold off only while a result is stuck at the output.
	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	// Configuration registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.write_length <= 4'd1;
			cfg_q.read_length  <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == i2cms_pkg::CFG_WRITE_LENGTH) begin
				cfg_q.write_length <= cfg_data;
			end else if (cfg_index == i2cms_pkg::CFG_READ_LENGTH) begin
				cfg_q.read_length <= cfg_data;
			end
		end
	end

	// Loads beyond the buffer depth are ignored.
	assign ram_we    = accept && (mode == i2cms_pkg::MODE_LOAD)
	                   && (32'(load_index) < BUF_DEPTH);
	assign ram_waddr = AW'(load_index);

	i2cms_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_tx_buffer (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(load_byte),
		.re   (accept),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	i2cms_ctrl #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode),
		.status_code(status_code),
		.rx_byte    (rx_byte),
		.cfg        (cfg_q),
		.rd_addr    (ram_raddr),
		.res        (res_d)
	);

	// Output register; the read data of the RAM lines up with it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	assign out_valid   = valid_s1;
	assign send_valid  = res_s1.send_valid;
	assign send_byte   = (res_s1.send_valid && res_s1.slot_ok) ? ram_rdata : 8'd0;
	assign set_start   = res_s1.set_start;
	assign clear_start = res_s1.clear_start;
	assign set_stop    = res_s1.set_stop;
	assign ack_drive   = res_s1.ack_drive;
	assign rx_valid    = res_s1.rx_valid;
	assign rx_index    = res_s1.rx_index;
	assign rx_data     = res_s1.rx_data;
	assign outcome     = res_s1.outcome;

	// Every accepted request yields a result in the next cycle.
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request produced no result");

	// A stalled result keeps its content and the RAM read data under it.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_stall |=> $stable(res_s1) && $stable(ram_rdata))
		else $error("stalled result changed");

	// A result never both sends a byte and delivers a received one.
	a_send_or_rx: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(res_s1.send_valid && res_s1.rx_valid))
		else $error("send and receive in one result");

	// START and STOP are never requested together.
	a_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(res_s1.set_start && res_s1.set_stop))
		else $error("START and STOP in one result");

endmodule

FILE: sv/i2cms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds the transmit buffer of the sequencer.
`timescale 1ns / 1ps

module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; read data holds when re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/i2cms_ctrl.sv
// Status-code decoder with the write index, read index and outcome registers.
// Depends on i2cms_pkg; drives the transmit buffer read address.
`timescale 1ns / 1ps

module i2cms_ctrl #(
	parameter int BUF_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [1:0]                   mode,
	input  logic [7:0]                   status_code,
	input  logic [7:0]                   rx_byte,
	input  i2cms_pkg::cfg_t              cfg,
	output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
	output i2cms_pkg::result_t           res
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int IW = $clog2(BUF_DEPTH + 1);
	localparam int CW = (IW + 1 > 5) ? IW + 1 : 5;
	localparam logic [IW-1:0] DEPTH_I = IW'(BUF_DEPTH);

	logic [IW-1:0] write_index_q, write_index_d;
	logic [IW-1:0] read_index_q, read_index_d;
	i2cms_pkg::outcome_t outcome_q, outcome_d;

	logic [IW-1:0] slot_idx;
	logic [IW-1:0] wi_bump;
	logic [IW-1:0] ri_bump;
	logic [CW-1:0] ri_plus;
	logic          ack_bump;
	logic          ack_keep;

	// Saturating increments and the ACK test before and after a receive.
	always_comb begin
		wi_bump  = (write_index_q < DEPTH_I) ? write_index_q + 1'b1 : DEPTH_I;
		ri_bump  = (read_index_q < DEPTH_I) ? read_index_q + 1'b1 : DEPTH_I;
		ri_plus  = CW'(read_index_q) + 1'b1;
		ack_keep = ri_plus < CW'(cfg.read_length);
		ack_bump = (CW'(ri_bump) + 1'b1) < CW'(cfg.read_length);
	end

	// Decode of one item into the next state and the result fields.
	always_comb begin
		write_index_d = write_index_q;
		read_index_d  = read_index_q;
		outcome_d     = outcome_q;
		slot_idx      = write_index_q;
		res           = '0;
		unique case (i2cms_pkg::mode_t'(mode))
			i2cms_pkg::MODE_LOAD: begin
			end
			i2cms_pkg::MODE_START: begin
				outcome_d     = i2cms_pkg::OUT_IDLE;
				res.set_start = 1'b1;
			end
			i2cms_pkg::MODE_STATUS: begin
				unique case (status_code)
					i2cms_pkg::ST_START: begin
						slot_idx        = '0;
						res.send_valid  = 1'b1;
						write_index_d   = IW'(1);
						res.clear_start = 1'b1;
					end
					i2cms_pkg::ST_RESTART: begin
						read_index_d    = '0;
						res.send_valid  = 1'b1;
						write_index_d   = wi_bump;
						res.clear_start = 1'b1;
					end
					i2cms_pkg::ST_SLA_W_ACK: begin
						if (cfg.write_length == 4'd1) begin
							res.set_stop = 1'b1;
							outcome_d    = i2cms_pkg::OUT_NO_DATA;
						end else begin
							res.send_valid = 1'b1;
							write_index_d  = wi_bump;
						end
					end
					i2cms_pkg::ST_DATA_W_ACK: begin
						if (CW'(write_index_q) < CW'(cfg.write_length)) begin
							res.send_valid = 1'b1;
							write_index_d  = wi_bump;
						end else if (cfg.read_length != 4'd0) begin
							res.set_start = 1'b1;
						end else begin
							res.set_stop = 1'b1;
							outcome_d    = i2cms_pkg::OUT_OK;
						end
					end
					i2cms_pkg::ST_DATA_W_NACK: begin
						res.set_stop = 1'b1;
						outcome_d    = i2cms_pkg::OUT_NACK_DATA;
					end
					i2cms_pkg::ST_SLA_R_ACK: begin
						res.ack_drive = ack_keep ? i2cms_pkg::ACK_ACK : i2cms_pkg::ACK_NACK;
					end
					i2cms_pkg::ST_DATA_R_ACK, i2cms_pkg::ST_DATA_R_NACK: begin
						// A byte beyond the buffer depth is dropped.
						if (read_index_q < DEPTH_I) begin
							res.rx_valid = 1'b1;
							res.rx_index = 4'(CW'(read_index_q));
							res.rx_data  = rx_byte;
						end
						read_index_d = ri_bump;
						if (status_code == i2cms_pkg::ST_DATA_R_ACK) begin
							res.ack_drive = ack_bump ? i2cms_pkg::ACK_ACK
							                         : i2cms_pkg::ACK_NACK;
						end else begin
							res.set_stop = 1'b1;
							outcome_d    = i2cms_pkg::OUT_OK;
						end
					end
					i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_SLA_R_NACK: begin
						res.set_stop = 1'b1;
						outcome_d    = i2cms_pkg::OUT_NACK_ADDR;
					end
					default: begin
						outcome_d = i2cms_pkg::OUT_ARB_LOST;
					end
				endcase
			end
			default: begin
			end
		endcase
		res.slot_ok = slot_idx < DEPTH_I;
		res.outcome = outcome_d;
	end

	assign rd_addr = slot_idx[AW-1:0];

	// State registers advance only on an accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q <= '0;
			read_index_q  <= '0;
			outcome_q     <= i2cms_pkg::OUT_IDLE;
		end else if (accept) begin
			write_index_q <= write_index_d;
			read_index_q  <= read_index_d;
			outcome_q     <= outcome_d;
		end
	end

endmodule

FILE: dv/tb_i2c_master_transfer_sequencer.sv
// Self-checking testbench for the I2C master transfer sequencer top level.
// Depends on i2cms_pkg and i2c_master_transfer_sequencer; holds its own scoreboard class.
`timescale 1ns / 1ps

module tb_i2c_master_transfer_sequencer;
	import i2cms_pkg::*;

	localparam int DEPTH       = 16;
	localparam int LONG_HOLD   = 40;
	localparam int TAIL_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 1100;
	localparam int PHASE_ITEMS = 90;

	// Mode value that the block does not decode.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Status codes outside the master-mode set, both ends of the byte range.
	localparam logic [7:0] ST_BOGUS_LOW  = 8'h00;
	localparam logic [7:0] ST_BOGUS_HIGH = 8'hFF;

	// One request on the input channel.
	typedef struct {
		logic [1:0] m;
		logic [3:0] lidx;
		logic [7:0] lbyte;
		logic [7:0] code;
		logic [7:0] rxb;
	} req_t;

	// One result on the output channel.
	typedef struct {
		logic       send_valid;
		logic [7:0] send_byte;
		logic       set_start;
		logic       clear_start;
		logic       set_stop;
		ack_t       ack_drive;
		logic       rx_valid;
		logic [3:0] rx_index;
		logic [7:0] rx_data;
		outcome_t   outcome;
	} xfer_result_t;

	// Scoreboard: tracks the sequencer state, predicts each result and checks
	// the results in order against the predictions.
	class xfer_scoreboard;
		logic [7:0]   tx_buf [DEPTH];
		logic [4:0]   wr_idx;
		logic [4:0]   rd_idx;
		logic [3:0]   wr_len;
		logic [3:0]   rd_len;
		outcome_t     outcome_now;
		xfer_result_t expected_q [$];
		int unsigned  errors;
		int unsigned  checked;

		function new();
			foreach (tx_buf[i]) tx_buf[i] = 8'h00;
			wr_idx = '0;
			rd_idx = '0;
			wr_len = 4'd1;
			rd_len = 4'd0;
			outcome_now = OUT_IDLE;
			errors = 0;
			checked = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
			case (idx)
				CFG_WRITE_LENGTH: wr_len = val;
				CFG_READ_LENGTH:  rd_len = val;
				default: ;
			endcase
		endfunction

		// Indexes stop at the buffer depth.
		function logic [4:0] bump(logic [4:0] v);
			return (v < DEPTH) ? v + 5'd1 : 5'(DEPTH);
		endfunction

		// Byte at the write index, then advance it; slots past the end read as zero.
		function logic [7:0] take_slot();
			logic [7:0] b;
			b = (wr_idx < DEPTH) ? tx_buf[wr_idx[3:0]] : 8'h00;
			wr_idx = bump(wr_idx);
			return b;
		endfunction

		// ACK while more bytes are still to come, NACK on the last one.
		function ack_t read_ack();
			return (rd_idx + 5'd1 < {1'b0, rd_len}) ? ACK_ACK : ACK_NACK;
		endfunction

		function void note_request(req_t q);
			xfer_result_t r;
			r.send_valid  = 1'b0;
			r.send_byte   = 8'h00;
			r.set_start   = 1'b0;
			r.clear_start = 1'b0;
			r.set_stop    = 1'b0;
			r.ack_drive   = ACK_NONE;
			r.rx_valid    = 1'b0;
			r.rx_index    = 4'd0;
			r.rx_data     = 8'h00;
			case (q.m)
				MODE_LOAD: tx_buf[q.lidx] = q.lbyte;
				MODE_START: begin
					outcome_now = OUT_IDLE;
					r.set_start = 1'b1;
				end
				MODE_STATUS: begin
					case (q.code)
						ST_START: begin
							wr_idx = '0;
							r.send_valid = 1'b1;
							r.send_byte = take_slot();
							r.clear_start = 1'b1;
						end
						ST_RESTART: begin
							rd_idx = '0;
							r.send_valid = 1'b1;
							r.send_byte = take_slot();
							r.clear_start = 1'b1;
						end
						ST_SLA_W_ACK: begin
							if (wr_len == 4'd1) begin
								r.set_stop = 1'b1;
								outcome_now = OUT_NO_DATA;
							end else begin
								r.send_valid = 1'b1;
								r.send_byte = take_slot();
							end
						end
						ST_DATA_W_ACK: begin
							if (wr_idx < {1'b0, wr_len}) begin
								r.send_valid = 1'b1;
								r.send_byte = take_slot();
							end else if (rd_len != 4'd0) begin
								r.set_start = 1'b1;
							end else begin
								r.set_stop = 1'b1;
								outcome_now = OUT_OK;
							end
						end
						ST_DATA_W_NACK: begin
							r.set_stop = 1'b1;
							outcome_now = OUT_NACK_DATA;
						end
						ST_SLA_R_ACK: r.ack_drive = read_ack();
						ST_DATA_R_ACK, ST_DATA_R_NACK: begin
							// Bytes past the buffer depth are dropped.
							if (rd_idx < DEPTH) begin
								r.rx_valid = 1'b1;
								r.rx_index = rd_idx[3:0];
								r.rx_data = q.rxb;
							end
							rd_idx = bump(rd_idx);
							if (q.code == ST_DATA_R_ACK) begin
								r.ack_drive = read_ack();
							end else begin
								r.set_stop = 1'b1;
								outcome_now = OUT_OK;
							end
						end
						ST_SLA_W_NACK, ST_SLA_R_NACK: begin
							r.set_stop = 1'b1;
							outcome_now = OUT_NACK_ADDR;
						end
						default: outcome_now = OUT_ARB_LOST;
					endcase
				end
				default: ;
			endcase
			r.outcome = outcome_now;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("result %0d %s is %0h, %0h predicted", checked, name, got, want));
		endtask

		task check_result(xfer_result_t got);
			xfer_result_t want;
			if (expected_q.size() == 0) begin
				report("result arrived with no request outstanding");
				return;
			end
			want = expected_q.pop_front();
			checked++;
			check_field("send_valid", got.send_valid, want.send_valid);
			check_field("send_byte", got.send_byte, want.send_byte);
			check_field("set_start", got.set_start, want.set_start);
			check_field("clear_start", got.clear_start, want.clear_start);
			check_field("set_stop", got.set_stop, want.set_stop);
			check_field("ack_drive", got.ack_drive, want.ack_drive);
			check_field("rx_valid", got.rx_valid, want.rx_valid);
			check_field("rx_index", got.rx_index, want.rx_index);
			check_field("rx_data", got.rx_data, want.rx_data);
			check_field("outcome", got.outcome, want.outcome);
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           mode;
	logic [3:0]           load_index;
	logic [7:0]           load_byte;
	logic [7:0]           status_code;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic                 send_valid;
	logic [7:0]           send_byte;
	logic                 set_start;
	logic                 clear_start;
	logic                 set_stop;
	logic [1:0]           ack_drive;
	logic                 rx_valid;
	logic [3:0]           rx_index;
	logic [7:0]           rx_data;
	logic [2:0]           outcome;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [3:0]           cfg_data;

	xfer_scoreboard sb;
	int unsigned    cycle_count = 0;
	int unsigned    items_sent = 0;
	int unsigned    n_transfers = 0;
	int unsigned    n_broken = 0;
	int unsigned    n_settings = 0;
	logic [3:0]     cur_wl = 4'd1;
	logic [3:0]     cur_rl = 4'd0;
	bit             tx_idle_en = 1'b0;
	bit             rx_idle_en = 1'b0;
	bit             hold_now = 1'b0;

	i2c_master_transfer_sequencer #(
		.BUF_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.load_index(load_index),
		.load_byte(load_byte),
		.status_code(status_code),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.send_valid(send_valid),
		.send_byte(send_byte),
		.set_start(set_start),
		.clear_start(clear_start),
		.set_stop(set_stop),
		.ack_drive(ack_drive),
		.rx_valid(rx_valid),
		.rx_index(rx_index),
		.rx_data(rx_data),
		.outcome(outcome),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog against a hung handshake.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
		$display("TEST FAILED");
		$finish;
	end

	// Receiver stall: short random bursts, plus one long hold-off on request.
	initial begin : result_stall
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				if (hold_now) begin
					hold_now = 1'b0;
					stall_left = LONG_HOLD;
				end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
					stall_left = $urandom_range(1, 4);
				end
			end
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// Output values are stable around the falling edge; a result seen here with
	// the stall low is taken at the next rising edge.
	always @(negedge clk) begin
		xfer_result_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.send_valid  = send_valid;
			seen.send_byte   = send_byte;
			seen.set_start   = set_start;
			seen.clear_start = clear_start;
			seen.set_stop    = set_stop;
			seen.ack_drive   = ack_t'(ack_drive);
			seen.rx_valid    = rx_valid;
			seen.rx_index    = rx_index;
			seen.rx_data     = rx_data;
			seen.outcome     = outcome_t'(outcome);
			sb.check_result(seen);
		end
	end

	function automatic req_t make_req(logic [1:0] m, logic [7:0] code);
		req_t q;
		q.m     = m;
		q.lidx  = 4'($urandom_range(0, 15));
		q.lbyte = 8'($urandom);
		q.code  = code;
		q.rxb   = 8'($urandom);
		return q;
	endfunction

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 9))
			0: return ST_START;
			1: return ST_RESTART;
			2: return ST_SLA_W_ACK;
			3: return ST_SLA_W_NACK;
			4: return ST_DATA_W_ACK;
			5: return ST_DATA_W_NACK;
			6: return ST_SLA_R_ACK;
			7: return ST_SLA_R_NACK;
			8: return ST_DATA_R_ACK;
			default: return ST_DATA_R_NACK;
		endcase
	endfunction

	function automatic logic [7:0] noise_code();
		return ($urandom_range(0, 1) == 0) ? pick_code() : 8'($urandom);
	endfunction

	// Offer one request, optionally after a short gap, and wait until it is taken.
	// Called at a rising edge; returns at the rising edge that accepted it.
	task automatic send_request(req_t q);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= q.m;
		load_index  <= q.lidx;
		load_byte   <= q.lbyte;
		status_code <= q.code;
		rx_byte     <= q.rxb;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		sb.note_request(q);
		items_sent++;
	endtask

	task automatic send_load(logic [3:0] idx, logic [7:0] b);
		req_t q;
		q = make_req(MODE_LOAD, 8'($urandom));
		q.lidx = idx;
		q.lbyte = b;
		send_request(q);
	endtask

	task automatic send_start();
		send_request(make_req(MODE_START, 8'($urandom)));
	endtask

	task automatic send_status(logic [7:0] code);
		send_request(make_req(MODE_STATUS, code));
	endtask

	// Stop offering and wait until every predicted result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Write both length registers; only called while the block is idle.
	task automatic configure(logic [3:0] wl, logic [3:0] rl);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_WRITE_LENGTH;
		cfg_data  <= wl;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		sb.write_reg(CFG_WRITE_LENGTH, wl);
		cfg_index <= CFG_READ_LENGTH;
		cfg_data  <= rl;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		sb.write_reg(CFG_READ_LENGTH, rl);
		cfg_valid <= 1'b0;
		cur_wl = wl;
		cur_rl = rl;
		n_settings++;
	endtask

	// One master transfer as the controller would report it under the current
	// lengths; a broken one is cut short and ends in a fault code.
	task automatic run_transfer(bit broken);
		logic [7:0] codes [$];
		int         n_write;
		int         cut;
		logic [7:0] fault;
		codes.push_back(ST_START);
		codes.push_back(ST_SLA_W_ACK);
		if (cur_wl != 4'd1) begin
			n_write = (cur_wl > 2) ? int'(cur_wl) - 2 : 0;
			repeat (n_write) codes.push_back(ST_DATA_W_ACK);
			codes.push_back(ST_DATA_W_ACK);
			if (cur_rl != 4'd0) begin
				codes.push_back(ST_RESTART);
				codes.push_back(ST_SLA_R_ACK);
				repeat (int'(cur_rl) - 1) codes.push_back(ST_DATA_R_ACK);
				codes.push_back(ST_DATA_R_NACK);
			end
		end
		if (broken) begin
			cut = $urandom_range(0, codes.size() - 1);
			while (codes.size() > cut) void'(codes.pop_back());
			case ($urandom_range(0, 3))
				0: fault = ST_SLA_W_NACK;
				1: fault = ST_DATA_W_NACK;
				2: fault = ST_SLA_R_NACK;
				default: fault = 8'($urandom);
			endcase
			codes.push_back(fault);
			n_broken++;
		end
		send_start();
		foreach (codes[i]) send_status(codes[i]);
		n_transfers++;
	endtask

	initial begin : stimulus
		req_t       q;
		int         phase;
		int         phase_end;
		int         pick;
		logic [7:0] burst_code;

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		mode        <= MODE_LOAD;
		load_index  <= 4'd0;
		load_byte   <= 8'h00;
		status_code <= ST_BOGUS_LOW;
		rx_byte     <= 8'h00;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_WRITE_LENGTH;
		cfg_data    <= 4'd0;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a full write-then-read transfer, every status code, and the
		// corner cases of the length registers.
		configure(4'd3, 4'd2);
		send_load(4'd0, 8'h00);
		send_load(4'd1, 8'hFF);
		send_load(4'd2, 8'h5A);
		send_load(4'd3, 8'hA5);
		send_load(4'd15, 8'h3C);
		send_request(make_req(MODE_UNUSED, 8'($urandom)));
		send_start();
		send_status(ST_START);
		send_status(ST_SLA_W_ACK);
		send_status(ST_DATA_W_ACK);
		send_status(ST_DATA_W_ACK);
		send_status(ST_RESTART);
		send_status(ST_SLA_R_ACK);
		q = make_req(MODE_STATUS, ST_DATA_R_ACK);
		q.rxb = 8'hFF;
		send_request(q);
		q = make_req(MODE_STATUS, ST_DATA_R_NACK);
		q.rxb = 8'h00;
		send_request(q);
		send_status(ST_DATA_W_NACK);
		send_status(ST_SLA_W_NACK);
		send_status(ST_SLA_R_NACK);
		send_status(ST_BOGUS_LOW);
		send_status(ST_BOGUS_HIGH);
		send_start();
		drain();

		// Address only: no data to send, then a plain STOP.
		configure(4'd1, 4'd0);
		send_status(ST_SLA_W_ACK);
		send_status(ST_DATA_W_ACK);
		drain();

		// Zero write length still sends after the address.
		configure(4'd0, 4'd15);
		send_status(ST_START);
		send_status(ST_SLA_W_ACK);
		send_status(ST_DATA_W_ACK);
		drain();

		// Fill every transmit slot so no later request reads an unwritten one.
		for (int i = 0; i < DEPTH; i++)
			send_load(4'(i), 8'($urandom));

		// Random phases, each under one register setting.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			drain();
			case (phase)
				0: configure(4'd1, 4'd0);
				1: configure(4'd15, 4'd15);
				2: configure(4'd0, 4'd15);
				3: configure(4'd15, 4'd0);
				default: configure(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			endcase
			if (ITEM_TARGET - items_sent <= PHASE_ITEMS + 30) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
				phase_end = ITEM_TARGET;
			end else begin
				tx_idle_en = ($urandom_range(0, 3) != 0);
				rx_idle_en = ($urandom_range(0, 3) != 0);
				phase_end = items_sent + PHASE_ITEMS;
			end
			// Long receiver hold while requests keep coming.
			if (phase == 1)
				hold_now = 1'b1;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					run_transfer($urandom_range(0, 3) == 0);
				end else if (pick < 72) begin
					send_load(4'($urandom_range(0, 15)), 8'($urandom));
				end else if (pick < 85) begin
					send_request(make_req(2'($urandom_range(0, 3)), noise_code()));
				end else if (pick < 93) begin
					// A repeated code can drive the indexes into saturation.
					burst_code = pick_code();
					repeat ($urandom_range(4, 20)) send_status(burst_code);
				end else begin
					send_start();
					send_status(noise_code());
				end
			end
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d requests under %0d register settings, %0d results checked.",
			items_sent, n_settings, sb.checked);
		$display("Included %0d master transfers, %0d of them cut short by a fault code.",
			n_transfers, n_broken);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
